// ===== hdl/ffha_pkg.sv =====
package ffha_pkg;

  localparam int unsigned REQ_W = 13;
  localparam int unsigned OFF_W = 12;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned RESET_HEAP_BYTES = 4096;
  localparam int unsigned MIN_HEAP_GRAN = 8;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] granted_offset;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_ANXT,
    S_AWR,
    S_FNXT,
    S_FPRV
  } state_e;

endpackage

// ===== hdl/first_fit_heap_allocator.sv =====
// Channel  | Signals                               | Direction | Transfer
// request  | start, busy, req_i                    | in        | start && !busy
// result   | res_valid_o, res_o                    | out       | res_valid_o, one cycle
// config   | cfg_valid_i, cfg_ready_o, cfg_data_i  | in        | cfg_valid_i && cfg_ready_o
// A request walks H headers, where H is at most HEAP_BYTES/16, and then makes zero to two
// extra header writes; the single header RAM port, one read per cycle, sets the walk rate.
// A zero-size allocation is answered in the cycle after it is accepted, with no walk.
// Reset leaves the heap as one free block at once; no clearing pass is needed.
// The result is shown for one cycle and cannot be stalled.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  ffha_pkg::req_t                      req_i,
  output logic                                res_valid_o,
  output ffha_pkg::res_t                      res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ffha_pkg::CFG_W-1:0]          cfg_data_i
);

  import ffha_pkg::*;

  localparam int unsigned SLOTS = HEAP_BYTES / 8;
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned GW = $clog2(SLOTS + 1);
  localparam int unsigned CW = (GW > 11) ? GW + 1 : 12;
  localparam int unsigned RESET_HG =
      (SLOTS < RESET_HEAP_BYTES / 8) ? SLOTS : RESET_HEAP_BYTES / 8;

  state_e state_q, state_d;
  logic          func_q, func_d;
  logic [CW-1:0] want_q, want_d;
  logic [CW-1:0] tgt_q, tgt_d;
  logic          tgt_ok_q, tgt_ok_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [IW-1:0] prev_q, prev_d;
  logic [IW-1:0] prev_sz_q, prev_sz_d;
  logic          prev_free_q, prev_free_d;
  logic [CW-1:0] rest_q, rest_d;
  logic [CW-1:0] rest_sz_q, rest_sz_d;
  logic [CW-1:0] sz_q, sz_d;
  logic [GW-1:0] hg_q, hg_d;
  logic          fresh_q, fresh_d;
  logic          rd_zero_q, rd_zero_d;
  logic          res_valid_q, res_valid_d;
  res_t          res_q, res_d;

  logic          we;
  logic [IW-1:0] waddr;
  logic [IW:0]   wdata;
  logic [IW-1:0] raddr;
  logic [IW:0]   rdata;

  logic          hdr_used;
  logic [IW-1:0] hdr_sz;
  logic [CW-1:0] sz_w;
  logic [CW-1:0] hg_w;
  logic [CW-1:0] next_w;
  logic [CW-1:0] merged;
  logic [CW+2:0] granted_w;
  logic [REQ_W:0] want_sum;
  logic [9:0]    cfg_gran;
  logic          cfg_we;
  logic          accept;

  ffha_hdr_ram #(
    .DEPTH(SLOTS),
    .WIDTH(IW + 1)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = start && !busy;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    if (rd_zero_q && fresh_q) begin
      hdr_sz   = IW'(hg_q - GW'(1));
      hdr_used = 1'b0;
    end else begin
      hdr_sz   = rdata[IW:1];
      hdr_used = rdata[0];
    end
  end

  assign sz_w      = CW'(hdr_sz);
  assign hg_w      = CW'(hg_q);
  assign next_w    = cur_q + sz_w + CW'(1);
  assign granted_w = {cur_q + CW'(1), 3'b000};
  assign want_sum  = {1'b0, req_i.request_bytes} + (REQ_W + 1)'(7);
  assign cfg_gran  = cfg_data_i[12:3];

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    want_d      = want_q;
    tgt_d       = tgt_q;
    tgt_ok_d    = tgt_ok_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_sz_d   = prev_sz_q;
    prev_free_d = prev_free_q;
    rest_d      = rest_q;
    rest_sz_d   = rest_sz_q;
    sz_d        = sz_q;
    hg_d        = hg_q;
    fresh_d     = fresh_q;
    rd_zero_d   = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = cur_q[IW-1:0];
    wdata       = '0;
    raddr       = next_w[IW-1:0];
    merged      = '0;

    unique case (state_q)
      S_IDLE: begin
        raddr = '0;
        if (cfg_we) begin
          fresh_d = 1'b1;
          if (CW'(cfg_gran) < CW'(MIN_HEAP_GRAN)) begin
            hg_d = GW'(MIN_HEAP_GRAN);
          end else if (CW'(cfg_gran) > CW'(SLOTS)) begin
            hg_d = GW'(SLOTS);
          end else begin
            hg_d = GW'(cfg_gran);
          end
        end
        if (accept) begin
          func_d      = req_i.func;
          want_d      = CW'(want_sum[REQ_W:3]);
          tgt_d       = CW'(req_i.payload_offset[OFF_W-1:3]);
          tgt_ok_d    = (req_i.payload_offset[2:0] == 3'b000);
          cur_d       = '0;
          prev_free_d = 1'b0;
          if (req_i.func == FUNC_ALLOC && req_i.request_bytes == '0) begin
            res_valid_d = 1'b1;
            res_d       = '0;
          end else begin
            rd_zero_d = 1'b1;
            state_d   = S_CHK;
          end
        end
      end

      S_CHK: begin
        if (func_q == FUNC_ALLOC) begin
          if (!hdr_used && sz_w >= want_q) begin
            if (sz_w - want_q >= CW'(2)) begin
              rest_d    = cur_q + want_q + CW'(1);
              rest_sz_d = sz_w - want_q - CW'(1);
              if (next_w < hg_w) begin
                state_d = S_ANXT;
              end else begin
                we      = 1'b1;
                waddr   = rest_d[IW-1:0];
                wdata   = {rest_sz_d[IW-1:0], 1'b0};
                state_d = S_AWR;
              end
            end else begin
              we          = 1'b1;
              wdata       = {hdr_sz, 1'b1};
              res_valid_d = 1'b1;
              res_d.ok    = 1'b1;
              res_d.granted_offset = granted_w[OFF_W-1:0];
              state_d     = S_IDLE;
            end
          end else begin
            cur_d = next_w;
            if (next_w >= hg_w) begin
              res_valid_d = 1'b1;
              res_d       = '0;
              state_d     = S_IDLE;
            end
          end
        end else begin
          if (tgt_ok_q && tgt_q == cur_q + CW'(1)) begin
            sz_d = sz_w;
            if (next_w < hg_w) begin
              state_d = S_FNXT;
            end else begin
              we    = 1'b1;
              wdata = {hdr_sz, 1'b0};
              if (prev_free_q) begin
                state_d = S_FPRV;
              end else begin
                res_valid_d = 1'b1;
                res_d.ok    = 1'b1;
                res_d.granted_offset = '0;
                state_d     = S_IDLE;
              end
            end
          end else begin
            prev_d      = cur_q[IW-1:0];
            prev_sz_d   = hdr_sz;
            prev_free_d = !hdr_used;
            cur_d       = next_w;
            if (next_w >= hg_w) begin
              res_valid_d = 1'b1;
              res_d       = '0;
              state_d     = S_IDLE;
            end
          end
        end
      end

      S_ANXT: begin
        merged = hdr_used ? rest_sz_q : rest_sz_q + sz_w + CW'(1);
        we      = 1'b1;
        waddr   = rest_q[IW-1:0];
        wdata   = {merged[IW-1:0], 1'b0};
        state_d = S_AWR;
      end

      S_AWR: begin
        we          = 1'b1;
        wdata       = {want_q[IW-1:0], 1'b1};
        res_valid_d = 1'b1;
        res_d.ok    = 1'b1;
        res_d.granted_offset = granted_w[OFF_W-1:0];
        state_d     = S_IDLE;
      end

      S_FNXT: begin
        merged = hdr_used ? sz_q : sz_q + sz_w + CW'(1);
        sz_d   = merged;
        we     = 1'b1;
        wdata  = {merged[IW-1:0], 1'b0};
        if (prev_free_q) begin
          state_d = S_FPRV;
        end else begin
          res_valid_d = 1'b1;
          res_d.ok    = 1'b1;
          res_d.granted_offset = '0;
          state_d     = S_IDLE;
        end
      end

      S_FPRV: begin
        merged      = CW'(prev_sz_q) + sz_q + CW'(1);
        we          = 1'b1;
        waddr       = prev_q;
        wdata       = {merged[IW-1:0], 1'b0};
        res_valid_d = 1'b1;
        res_d.ok    = 1'b1;
        res_d.granted_offset = '0;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (we && waddr == '0) begin
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hg_q        <= GW'(RESET_HG);
      fresh_q     <= 1'b1;
      rd_zero_q   <= 1'b0;
      res_valid_q <= 1'b0;
      prev_free_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hg_q        <= hg_d;
      fresh_q     <= fresh_d;
      rd_zero_q   <= rd_zero_d;
      res_valid_q <= res_valid_d;
      prev_free_q <= prev_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    want_q    <= want_d;
    tgt_q     <= tgt_d;
    tgt_ok_q  <= tgt_ok_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    prev_sz_q <= prev_sz_d;
    rest_q    <= rest_d;
    rest_sz_q <= rest_sz_d;
    sz_q      <= sz_d;
    res_q     <= res_d;
  end

`ifndef NO_ASSERTIONS
  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("Result shown while a walk is still running.");

  a_zero_req_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.func == FUNC_ALLOC && req_i.request_bytes == '0)
      |=> (res_valid_o && !res_o.ok))
    else $error("Zero-size allocation did not fail at once.");

  a_free_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && busy == 1'b0 && $past(state_q) != S_IDLE && func_q == FUNC_FREE)
      |-> (res_o.granted_offset == '0))
    else $error("Free result carries a nonzero offset.");

  a_grant_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.ok) |-> (res_o.granted_offset[2:0] == 3'b000))
    else $error("Granted offset is not a multiple of eight.");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(waddr) < hg_w))
    else $error("Header write beyond the heap in use.");
`endif

endmodule

// ===== hdl/ffha_hdr_ram.sv =====
module ffha_hdr_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  localparam int unsigned HEAP_BYTES  = 4096;
  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned HDR_SLOTS   = HEAP_BYTES / HDR_BYTES;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 62;
  localparam int          HEAP_PLAN [PHASES] = '{64, 4096, -1, 1000, 8191, 71, -1, 0};

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             func;
    logic [REQ_W-1:0] nbytes;
    logic [OFF_W-1:0] poff;
    bit               typed;
    logic             ok;
    logic [OFF_W-1:0] goff;
  } dir_row_t;

  // Configuration rows carry the new heap size in the nbytes column.
  localparam int unsigned DIR_ROWS = 25;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, FUNC_ALLOC, 13'd0,    12'd4095, 1'b1, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd8191, 12'd0,    1'b1, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd4089, 12'd0,    1'b1, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd1,    12'd0,    1'b1, 1'b1, 12'd8},
    '{ROW_ITEM, FUNC_ALLOC, 13'd4072, 12'd0,    1'b1, 1'b1, 12'd24},
    '{ROW_ITEM, FUNC_ALLOC, 13'd8,    12'd0,    1'b1, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd0,    1'b1, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_FREE,  13'd8191, 12'd4095, 1'b1, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd8,    1'b1, 1'b1, 12'd0},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd8,    1'b1, 1'b1, 12'd0},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd24,   1'b1, 1'b1, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd4088, 12'd0,    1'b1, 1'b1, 12'd8},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd8,    1'b1, 1'b1, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd4080, 12'd0,    1'b1, 1'b1, 12'd8},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd8,    1'b1, 1'b1, 12'd0},
    '{ROW_CFG,  FUNC_ALLOC, 13'd0,    12'd0,    1'b0, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd57,   12'd0,    1'b1, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd56,   12'd0,    1'b1, 1'b1, 12'd8},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd8,    1'b1, 1'b1, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd24,   12'd0,    1'b0, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd24,   12'd0,    1'b0, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd8,    1'b0, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_FREE,  13'd0,    12'd40,   1'b0, 1'b0, 12'd0},
    '{ROW_CFG,  FUNC_ALLOC, 13'd8191, 12'd0,    1'b0, 1'b0, 12'd0},
    '{ROW_ITEM, FUNC_ALLOC, 13'd100,  12'd0,    1'b0, 1'b0, 12'd0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             res_valid_o;
  res_t             res_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  logic [9:0]  hdr_mem [HDR_SLOTS];
  int unsigned heap_limit;
  res_t        grant_q [$];
  int unsigned live_blocks [$];
  int unsigned last_freed;
  int unsigned err_cnt;
  int unsigned n_items;
  int unsigned n_grants;
  int unsigned n_found;
  int unsigned n_cfg;

  first_fit_heap_allocator #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned hdr_size(input int unsigned off);
    return 32'(hdr_mem[(off / HDR_BYTES) % HDR_SLOTS][9:1]) * HDR_BYTES;
  endfunction

  function automatic bit hdr_used(input int unsigned off);
    return hdr_mem[(off / HDR_BYTES) % HDR_SLOTS][0];
  endfunction

  function automatic void hdr_write(input int unsigned off, input int unsigned size,
                                    input bit used);
    hdr_mem[(off / HDR_BYTES) % HDR_SLOTS] = {9'(size / HDR_BYTES), used};
  endfunction

  function automatic bit heap_alloc(input int unsigned nbytes, output int unsigned grant);
    int unsigned want;
    int unsigned cur;
    int unsigned sz;
    int unsigned rest_off;
    int unsigned rest_sz;
    int unsigned nxt;
    grant = 0;
    if (nbytes == 0) return 1'b0;
    want = (nbytes + 7) & ~32'd7;
    cur = 0;
    while (cur < heap_limit) begin
      sz = hdr_size(cur);
      if (!hdr_used(cur) && sz >= want) begin
        if (sz - want >= 2 * HDR_BYTES) begin
          rest_off = cur + HDR_BYTES + want;
          rest_sz  = sz - want - HDR_BYTES;
          nxt      = rest_off + HDR_BYTES + rest_sz;
          if (nxt < heap_limit && !hdr_used(nxt)) rest_sz += hdr_size(nxt) + HDR_BYTES;
          hdr_write(rest_off, rest_sz, 1'b0);
          hdr_write(cur, want, 1'b1);
        end else begin
          hdr_write(cur, sz, 1'b1);
        end
        grant = cur + HDR_BYTES;
        return 1'b1;
      end
      cur += HDR_BYTES + sz;
    end
    return 1'b0;
  endfunction

  function automatic bit heap_free(input int unsigned p);
    int unsigned cur;
    int unsigned prev;
    int unsigned sz;
    int unsigned nxt;
    bit          have_prev;
    cur = 0;
    prev = 0;
    have_prev = 1'b0;
    while (cur < heap_limit) begin
      sz = hdr_size(cur);
      if (cur + HDR_BYTES == p) begin
        nxt = cur + HDR_BYTES + sz;
        if (nxt < heap_limit && !hdr_used(nxt)) sz += hdr_size(nxt) + HDR_BYTES;
        hdr_write(cur, sz, 1'b0);
        if (have_prev && !hdr_used(prev)) begin
          hdr_write(prev, hdr_size(prev) + sz + HDR_BYTES, 1'b0);
        end
        return 1'b1;
      end
      prev = cur;
      have_prev = 1'b1;
      cur += HDR_BYTES + sz;
    end
    return 1'b0;
  endfunction

  task automatic drain_results();
    start = 1'b0;
    do @(negedge clk_i); while (grant_q.size() != 0);
  endtask

  task automatic set_heap_size(input logic [CFG_W-1:0] value);
    int unsigned sz;
    drain_results();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sz = 32'(value) & ~32'd7;
    if (sz < 64) sz = 64;
    if (sz > HEAP_BYTES) sz = HEAP_BYTES;
    heap_limit = sz;
    hdr_write(0, heap_limit - HDR_BYTES, 1'b0);
    live_blocks.delete();
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic issue_request(input req_t item, input int unsigned gap, input bit typed,
                               input res_t typed_res);
    res_t        pred;
    int unsigned goff;
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = item;
    do @(posedge clk_i); while (busy !== 1'b0);
    n_items++;
    if (item.func == FUNC_ALLOC) begin
      pred.ok = heap_alloc(32'(item.request_bytes), goff);
      pred.granted_offset = pred.ok ? goff[OFF_W-1:0] : '0;
      if (pred.ok) begin
        n_grants++;
        live_blocks.push_back(goff);
      end
    end else begin
      pred.ok = heap_free(32'(item.payload_offset));
      pred.granted_offset = '0;
      if (pred.ok) n_found++;
    end
    grant_q.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (grant_q.size() == 0) begin
        $error("result with no request pending: ok %0d granted_offset %0d",
               res_o.ok, res_o.granted_offset);
        err_cnt++;
      end else begin
        want = grant_q.pop_front();
        if (res_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, res_o.ok);
          err_cnt++;
        end
        if (res_o.granted_offset !== want.granted_offset) begin
          $error("granted_offset: expected %0d, got %0d",
                 want.granted_offset, res_o.granted_offset);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    dir_row_t         row;
    req_t             item;
    res_t             want;
    int unsigned      gap;
    int unsigned      pick;
    int unsigned      idx;
    logic [CFG_W-1:0] hs;
    bit               steady;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    err_cnt     = 0;
    n_items     = 0;
    n_grants    = 0;
    n_found     = 0;
    n_cfg       = 0;
    last_freed  = HDR_BYTES;
    for (int i = 0; i < HDR_SLOTS; i++) hdr_mem[i] = '0;
    heap_limit = RESET_HEAP_BYTES;
    hdr_write(0, heap_limit - HDR_BYTES, 1'b0);
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      if (row.kind == ROW_CFG) begin
        set_heap_size(row.nbytes);
      end else begin
        item.func           = row.func;
        item.request_bytes  = row.nbytes;
        item.payload_offset = row.poff;
        want.ok             = row.ok;
        want.granted_offset = row.goff;
        issue_request(item, $urandom_range(0, 3), row.typed, want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      hs = (HEAP_PLAN[ph] < 0) ? CFG_W'($urandom_range(0, 8191)) : CFG_W'(HEAP_PLAN[ph]);
      set_heap_size(hs);
      steady = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        item.request_bytes  = REQ_W'($urandom_range(0, 8191));
        item.payload_offset = OFF_W'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 40 && live_blocks.size() != 0) begin
          idx = $urandom_range(0, live_blocks.size() - 1);
          item.func           = FUNC_FREE;
          item.payload_offset = OFF_W'(live_blocks[idx]);
          last_freed          = live_blocks[idx];
          live_blocks.delete(idx);
        end else if (pick < 45) begin
          item.func = FUNC_FREE;
        end else if (pick < 48) begin
          item.func           = FUNC_FREE;
          item.payload_offset = OFF_W'(last_freed);
        end else if (pick < 52) begin
          item.func = FUNC_ALLOC;
          if (pick == 48) item.request_bytes = '0;
        end else begin
          item.func = FUNC_ALLOC;
          pick = $urandom_range(0, 99);
          if (pick < 50) item.request_bytes = REQ_W'($urandom_range(1, 32));
          else if (pick < 85) item.request_bytes = REQ_W'($urandom_range(1, heap_limit / 4));
          else item.request_bytes = REQ_W'($urandom_range(1, heap_limit));
        end
        gap = steady ? 0 : $urandom_range(0, 7);
        issue_request(item, gap, 1'b0, '0);
        if (n == PHASE_ITEMS / 2 || $urandom_range(0, 31) == 0) drain_results();
      end
    end

    drain_results();
    repeat (16) @(negedge clk_i);
    $display("Summary: %0d requests over %0d heap size writes.", n_items, n_cfg);
    $display("Summary: %0d allocations granted, %0d frees matched a block.",
             n_grants, n_found);
    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ffha_pkg.sv
hdl/ffha_hdr_ram.sv
hdl/first_fit_heap_allocator.sv
dv/tb.sv
